### rtl/dpb_pkg.sv
// Shared types, widths and constants for the depth pixel back-projection block.
`default_nettype none

package dpb_pkg;

    // Field widths
    localparam int FRAME_REG_W = 11;
    localparam int K_W         = 24;
    localparam int DEPTH_W     = 16;
    localparam int COLOR_W     = 8;
    localparam int COORD_W     = 24;

    // Frame size arithmetic covers sizes up to 4096 and the 11-bit registers
    localparam int SIZE_W      = 13;
    // |2*pos - 2*floor(size/2) + 1| stays below 2*4096
    localparam int MAG_W       = 13;

    // Back-end datapath
    localparam int P1_W        = MAG_W + DEPTH_W;
    localparam int P2_W        = P1_W + K_W;
    localparam int ROUND_SHIFT = 25;
    localparam int ROUND_W     = P2_W + 1 - ROUND_SHIFT;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Default size limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Config port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [FRAME_REG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FRAME_REG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [K_W-1:0]         RST_INV_FOCAL    = 24'd31957;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_INVERSE_FOCAL = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [FRAME_REG_W-1:0] frame_width;
        logic [FRAME_REG_W-1:0] frame_height;
        logic [K_W-1:0]         inverse_focal;
    } cfg_t;

    // One classified pixel as handed from front to back
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               ok;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [MAG_W-1:0]   x_mag;
        logic               x_neg;
        logic [MAG_W-1:0]   y_mag;
        logic               y_neg;
        logic               frame_end;
    } item_t;

endpackage

`default_nettype wire

### rtl/dpb_queue.sv
// Small register queue decoupling the front end from the back end.
`default_nettype none

module dpb_queue #(
    parameter int DEPTH = dpb_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire dpb_pkg::item_t push_item,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output dpb_pkg::item_t      pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dpb_pkg::item_t    entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/dpb_front.sv
// Front end: raster counters, frame-end detection and per-axis offset magnitude.
`default_nettype none

module dpb_front #(
    parameter int MAX_WIDTH  = dpb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dpb_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dpb_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dpb_pkg::DEPTH_W-1:0]   depth_mm,
    input  wire logic                          depth_ok,
    input  wire logic [dpb_pkg::COLOR_W-1:0]   red_in,
    input  wire logic [dpb_pkg::COLOR_W-1:0]   green_in,
    input  wire logic [dpb_pkg::COLOR_W-1:0]   blue_in,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output dpb_pkg::item_t                     push_item
);

    localparam int SW    = dpb_pkg::SIZE_W;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SW-1:0]    w_eff, h_eff, col_ext, row_ext;
    logic             last_col, last_row, accept;
    logic [dpb_pkg::MAG_W-1:0] x_mag, y_mag;
    logic             x_neg, y_neg;

    // Zero reads as one, above the limit reads as the limit
    function automatic logic [SW-1:0] clamp_size(
        input logic [dpb_pkg::FRAME_REG_W-1:0] v,
        input logic [SW-1:0]                   maxv
    );
        logic [SW-1:0] ve;
        ve = SW'(v);
        if (ve == '0)
        begin
            return SW'(1);
        end
        else if (ve > maxv)
        begin
            return maxv;
        end
        return ve;
    endfunction

    // |2*pos + 1 - 2*floor(size/2)| and its sign
    function automatic logic [dpb_pkg::MAG_W:0] axis_mag(
        input logic [SW-1:0] pos,
        input logic [SW-1:0] size
    );
        logic [SW:0] odd_pos;
        logic [SW:0] twice_half;
        logic [SW:0] diff;
        logic        neg;
        odd_pos    = {pos, 1'b1};
        twice_half = {1'b0, size[SW-1:1], 1'b0};
        neg        = (twice_half > odd_pos);
        diff       = neg ? (twice_half - odd_pos) : (odd_pos - twice_half);
        return {dpb_pkg::MAG_W'(diff), neg};
    endfunction

    assign w_eff   = clamp_size(cfg.frame_width, SW'(MAX_WIDTH));
    assign h_eff   = clamp_size(cfg.frame_height, SW'(MAX_HEIGHT));
    assign col_ext = SW'(col_reg);
    assign row_ext = SW'(row_reg);

    // A counter left past the end by a smaller size counts as the last one
    assign last_col = (col_ext >= w_eff - 1'b1);
    assign last_row = (row_ext >= h_eff - 1'b1);

    assign {x_mag, x_neg} = axis_mag(col_ext, w_eff);
    assign {y_mag, y_neg} = axis_mag(row_ext, h_eff);

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        push_item.depth     = depth_mm;
        push_item.ok        = depth_ok;
        push_item.red       = red_in;
        push_item.green     = green_in;
        push_item.blue      = blue_in;
        push_item.x_mag     = x_mag;
        push_item.x_neg     = x_neg;
        push_item.y_mag     = y_mag;
        push_item.y_neg     = y_neg;
        push_item.frame_end = last_col && last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

### rtl/dpb_back.sv
// Back end: three-stage multiply, round and saturate pipeline with output register.
`default_nettype none

module dpb_back (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [dpb_pkg::K_W-1:0]              inverse_focal,
    input  wire logic                                 pop_valid,
    output logic                                      pop_ready,
    input  wire dpb_pkg::item_t                       pop_item,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [dpb_pkg::COORD_W-1:0]        x_mm,
    output logic signed [dpb_pkg::COORD_W-1:0]        y_mm,
    output logic [dpb_pkg::DEPTH_W-1:0]               z_mm,
    output logic                                      point_valid,
    output logic [dpb_pkg::COLOR_W-1:0]               red_out,
    output logic [dpb_pkg::COLOR_W-1:0]               green_out,
    output logic [dpb_pkg::COLOR_W-1:0]               blue_out,
    output logic                                      frame_end
);

    localparam int P1_W = dpb_pkg::P1_W;
    localparam int P2_W = dpb_pkg::P2_W;
    localparam int RW   = dpb_pkg::ROUND_W;
    localparam int CW   = dpb_pkg::COORD_W;

    logic            v1_reg, v2_reg, v3_reg;
    logic            en1, en2, en3;
    dpb_pkg::item_t  it1_reg, it2_reg;
    logic [P1_W-1:0] px1_reg, py1_reg;
    logic [P2_W-1:0] px2_reg, py2_reg;
    logic [CW-1:0]   x_next, y_next;

    // Round to nearest, ties away from zero, then saturate to the 24-bit range
    function automatic logic [CW-1:0] round_sat(
        input logic [P2_W-1:0] mag,
        input logic            neg
    );
        logic [P2_W:0] sum;
        logic [RW-1:0] r;
        sum = {1'b0, mag} + ((P2_W + 1)'(1) << (dpb_pkg::ROUND_SHIFT - 1));
        r   = sum[P2_W:dpb_pkg::ROUND_SHIFT];
        if (neg)
        begin
            if (r > (RW'(1) << (CW - 1)))
            begin
                r = RW'(1) << (CW - 1);
            end
            return CW'(RW'(0) - r);
        end
        if (r > ((RW'(1) << (CW - 1)) - 1'b1))
        begin
            r = (RW'(1) << (CW - 1)) - 1'b1;
        end
        return r[CW-1:0];
    endfunction

    assign en3       = !v3_reg || out_ready;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign pop_ready = en1;
    assign out_valid = v3_reg;

    assign x_next = round_sat(px2_reg, it2_reg.x_neg);
    assign y_next = round_sat(py2_reg, it2_reg.y_neg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pop_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && pop_valid)
        begin
            it1_reg <= pop_item;
            px1_reg <= P1_W'(pop_item.x_mag) * P1_W'(pop_item.depth);
            py1_reg <= P1_W'(pop_item.y_mag) * P1_W'(pop_item.depth);
        end
        if (en2 && v1_reg)
        begin
            it2_reg <= it1_reg;
            px2_reg <= P2_W'(px1_reg) * P2_W'(inverse_focal);
            py2_reg <= P2_W'(py1_reg) * P2_W'(inverse_focal);
        end
        if (en3 && v2_reg)
        begin
            x_mm        <= it2_reg.ok ? x_next : '0;
            y_mm        <= it2_reg.ok ? y_next : '0;
            z_mm        <= it2_reg.ok ? it2_reg.depth : '0;
            point_valid <= it2_reg.ok;
            red_out     <= it2_reg.red;
            green_out   <= it2_reg.green;
            blue_out    <= it2_reg.blue;
            frame_end   <= it2_reg.frame_end;
        end
    end

endmodule

`default_nettype wire

### rtl/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection block: config registers, front, queue, back.
`default_nettype none

// Turns a raster-order stream of depth pixels into 3-D points with a pinhole
// camera model: X = (col - cx) * Z * k and Y = (row - cy) * Z * k in whole
// millimetres (rounded to nearest, ties away from zero, saturated to 24-bit
// signed), Z passed through, colour passed through, and frame_end on the last
// pixel of each frame. cx = floor(width/2) - 0.5, same for cy; k is
// inverse_focal_q24 / 2^24. Pixels with depth_ok low give zero coordinates and
// point_valid low. The front end keeps the column and row counters and hands
// each classified pixel through a two-entry queue to the back end, a
// three-stage pipeline (depth times offset, times k, round and saturate into
// the output register). Throughput is one transaction per clock as long as
// out_ready stays high; an accepted input passes through a queue entry, then
// the two chained multiplies, each followed by a register, with round and
// saturate feeding the output register. Size registers read 0 as 1 and clamp
// at MAX_WIDTH / MAX_HEIGHT. Configuration writes are always accepted
// (cfg_ready is tied high); index 3 is ignored. Write configuration only while
// no transaction is in flight.
module depth_pixel_backprojection #(
    parameter int MAX_WIDTH  = dpb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dpb_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [dpb_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0]       cfg_data,
    // pixel input channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [dpb_pkg::DEPTH_W-1:0]          depth_mm,
    input  wire logic                                 depth_ok,
    input  wire logic [dpb_pkg::COLOR_W-1:0]          red_in,
    input  wire logic [dpb_pkg::COLOR_W-1:0]          green_in,
    input  wire logic [dpb_pkg::COLOR_W-1:0]          blue_in,
    // point output channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [dpb_pkg::COORD_W-1:0]        x_mm,
    output logic signed [dpb_pkg::COORD_W-1:0]        y_mm,
    output logic [dpb_pkg::DEPTH_W-1:0]               z_mm,
    output logic                                      point_valid,
    output logic [dpb_pkg::COLOR_W-1:0]               red_out,
    output logic [dpb_pkg::COLOR_W-1:0]               green_out,
    output logic [dpb_pkg::COLOR_W-1:0]               blue_out,
    output logic                                      frame_end
);

    dpb_pkg::cfg_t  cfg_reg, cfg_next;
    dpb_pkg::item_t push_item, pop_item;
    logic           push_valid, push_ready;
    logic           pop_valid, pop_ready;

    // Config registers: no back-pressure
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (dpb_pkg::cfg_reg_t'(cfg_index))
                dpb_pkg::REG_FRAME_WIDTH:
                begin
                    cfg_next.frame_width = cfg_data[dpb_pkg::FRAME_REG_W-1:0];
                end
                dpb_pkg::REG_FRAME_HEIGHT:
                begin
                    cfg_next.frame_height = cfg_data[dpb_pkg::FRAME_REG_W-1:0];
                end
                dpb_pkg::REG_INVERSE_FOCAL:
                begin
                    cfg_next.inverse_focal = cfg_data[dpb_pkg::K_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= dpb_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height  <= dpb_pkg::RST_FRAME_HEIGHT;
            cfg_reg.inverse_focal <= dpb_pkg::RST_INV_FOCAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: counters and per-pixel classification
    dpb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .depth_mm   (depth_mm),
        .depth_ok   (depth_ok),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decoupling queue
    dpb_queue #(
        .DEPTH (dpb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: multiply, round, saturate, output register
    dpb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .inverse_focal (cfg_reg.inverse_focal),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .x_mm          (x_mm),
        .y_mm          (y_mm),
        .z_mm          (z_mm),
        .point_valid   (point_valid),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .frame_end     (frame_end)
    );

    // An invalid pixel carries all-zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> x_mm == '0 && y_mm == '0 && z_mm == '0)
    else $error("invalid point with nonzero coordinates");

    // Zero depth projects to the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid && z_mm == '0 |-> x_mm == '0 && y_mm == '0)
    else $error("zero depth gave nonzero X or Y");

    // A full queue that stalls the front must leave the back end either stalled or with a queue entry to take
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> !pop_ready || pop_valid)
    else $error("queue full but back end starved");

endmodule

`default_nettype wire
